// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define C2GW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("C2GW same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define C2GW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("C2GW next-cycle check failed");

`endif

// ===== sv/c2gw_pkg.sv =====
package c2gw_pkg;

  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned LEAP_W  = 8;
  localparam int unsigned WEEK_W  = 13;
  localparam int unsigned TOW_W   = 20;

  // Internal widths, sized for years up to 2235.
  localparam int unsigned YOFF_W  = 8;   // years since the epoch year
  localparam int unsigned LCNT_W  = 7;   // leap days before the year
  localparam int unsigned DBM_W   = 9;   // days before month, leap day added
  localparam int unsigned DN_W    = 17;  // days since epoch, non-negative
  localparam int unsigned TOD_W   = 17;  // raw time-of-day seconds
  localparam int unsigned TODL_W  = 18;  // time of day plus leap seconds
  localparam int unsigned QW_W    = 14;  // week count before carry

  localparam logic [YEAR_W-1:0]  EPOCH_YEAR  = 12'd1980;
  localparam logic [YEAR_W-1:0]  CENT_SKIP_A = 12'd2100;
  localparam logic [YEAR_W-1:0]  CENT_SKIP_B = 12'd2200;
  localparam logic [MONTH_W-1:0] MONTH_JAN   = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;
  localparam logic [LEAP_W-1:0]  LEAP_RESET  = 8'd17;
  localparam int unsigned        EPOCH_DAY     = 6;
  localparam int unsigned        SECS_PER_DAY  = 86400;
  localparam int unsigned        SECS_PER_WEEK = 604800;
  localparam int unsigned        SECS_PER_HOUR = 3600;
  localparam int unsigned        SECS_PER_MIN  = 60;
  localparam int unsigned        DAYS_PER_YEAR = 365;

  // floor(x/7) == (x * DIV7_MULT) >> DIV7_SHIFT for all x below 349525.
  localparam int unsigned DIV7_MULT  = 149797;
  localparam int unsigned DIV7_SHIFT = 20;
  localparam int unsigned DIV7_PW    = DN_W + 18;

  typedef struct packed {
    logic              err;
    logic [DN_W-1:0]   dn;
    logic [TODL_W-1:0] tod;
  } day_res_t;

  function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [DBM_W-1:0] d;
    unique case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== sv/c2gw_day_count.sv =====
module c2gw_day_count
  import c2gw_pkg::*;
#(
  parameter int unsigned MAX_YEAR = 2099
) (
  input  logic                clk,
  input  logic [1:0]          en,
  input  logic [YEAR_W-1:0]   year,
  input  logic [MONTH_W-1:0]  month,
  input  logic [DAY_W-1:0]    day,
  input  logic [HOUR_W-1:0]   hour,
  input  logic [MIN_W-1:0]    minute,
  input  logic [SEC_W-1:0]    second,
  input  logic [LEAP_W-1:0]   leap_seconds,
  output day_res_t            res
);

  // Stage one: range checks, leap-day count, month offset and time-of-day seconds.
  logic              err1_nxt, err1_r;
  logic [YOFF_W-1:0] yoff_nxt, yoff_r;
  logic [LCNT_W-1:0] lcnt_nxt, lcnt_r;
  logic [DBM_W-1:0]  adj_nxt, adj_r;
  logic [DAY_W-1:0]  day_r;
  logic [TOD_W-1:0]  tod_nxt, tod_r;
  logic              is_leap;
  logic [YOFF_W:0]   yoff_rnd;

  always_comb begin
    err1_nxt = (year < EPOCH_YEAR) || (year > YEAR_W'(MAX_YEAR)) ||
               (month < MONTH_JAN) || (month > MONTH_DEC);
    yoff_nxt = YOFF_W'(year - EPOCH_YEAR);
    // Years since the epoch share their low two bits with the year itself.
    is_leap  = (yoff_nxt[1:0] == 2'b00) && (year != CENT_SKIP_A) && (year != CENT_SKIP_B);
    yoff_rnd = (YOFF_W+1)'(yoff_nxt) + (YOFF_W+1)'(3);
    lcnt_nxt = LCNT_W'(yoff_rnd >> 2) - LCNT_W'(year > CENT_SKIP_A)
             - LCNT_W'(year > CENT_SKIP_B);
    adj_nxt  = days_before_month(month) + DBM_W'((month > MONTH_FEB) && is_leap);
    tod_nxt  = TOD_W'(hour) * TOD_W'(SECS_PER_HOUR) + TOD_W'(minute) * TOD_W'(SECS_PER_MIN)
             + TOD_W'(second);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      err1_r <= err1_nxt;
      yoff_r <= yoff_nxt;
      lcnt_r <= lcnt_nxt;
      adj_r  <= adj_nxt;
      day_r  <= day;
      tod_r  <= tod_nxt;
    end
  end

  // Stage two: day number, flagged as an error when negative, plus leap seconds on the time of day.
  logic [DN_W:0] dn_sum;
  day_res_t      res_nxt, res_r;

  always_comb begin
    dn_sum = (DN_W+1)'(yoff_r) * (DN_W+1)'(DAYS_PER_YEAR) + (DN_W+1)'(lcnt_r)
           + (DN_W+1)'(adj_r) + (DN_W+1)'(day_r) - (DN_W+1)'(EPOCH_DAY);
    res_nxt.err = err1_r || dn_sum[DN_W];
    res_nxt.dn  = dn_sum[DN_W-1:0];
    res_nxt.tod = TODL_W'(tod_r) + TODL_W'(leap_seconds);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== sv/c2gw_week_split.sv =====
module c2gw_week_split
  import c2gw_pkg::*;
(
  input  logic              clk,
  input  logic [2:0]        en,
  input  day_res_t          res,
  output logic [WEEK_W-1:0] week_number,
  output logic [TOW_W-1:0]  time_of_week,
  output logic              date_error
);

  // Stage three: week count by reciprocal multiply.
  logic [DIV7_PW-1:0] prod;
  logic [QW_W-1:0]    q3_r;
  logic [DN_W-1:0]    dn3_r;
  logic [TODL_W-1:0]  tod3_r;
  logic               err3_r;

  assign prod = DIV7_PW'(res.dn) * DIV7_PW'(DIV7_MULT);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      q3_r   <= prod[DIV7_SHIFT +: QW_W];
      dn3_r  <= res.dn;
      tod3_r <= res.tod;
      err3_r <= res.err;
    end
  end

  // Stage four: day of week and uncorrected time of week.
  logic [2:0]       dow;
  logic [TOW_W-1:0] tow4_nxt, tow4_r;
  logic [QW_W-1:0]  q4_r;
  logic             err4_r;

  always_comb begin
    dow      = 3'(dn3_r - DN_W'(q3_r) * DN_W'(7));
    tow4_nxt = TOW_W'(dow) * TOW_W'(SECS_PER_DAY) + TOW_W'(tod3_r);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      tow4_r <= tow4_nxt;
      q4_r   <= q3_r;
      err4_r <= err3_r;
    end
  end

  // Stage five: carry a full week and clear the result on error.
  logic              carry;
  logic [QW_W-1:0]   wn_sum;
  logic [WEEK_W-1:0] wn_nxt, wn_r;
  logic [TOW_W-1:0]  tow_nxt, tow_r;
  logic              err_r;

  always_comb begin
    carry   = tow4_r >= TOW_W'(SECS_PER_WEEK);
    wn_sum  = q4_r + QW_W'(carry);
    wn_nxt  = err4_r ? '0 : wn_sum[WEEK_W-1:0];
    tow_nxt = err4_r ? '0 : (carry ? tow4_r - TOW_W'(SECS_PER_WEEK) : tow4_r);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      wn_r  <= wn_nxt;
      tow_r <= tow_nxt;
      err_r <= err4_r;
    end
  end

  assign week_number  = wn_r;
  assign time_of_week = tow_r;
  assign date_error   = err_r;

endmodule

// ===== sv/calendar_to_gps_week_time_core.sv =====
// Calendar date and time of day to GPS week number and time of week.
// Input stream: each in_ transaction carries one UTC timestamp; the block
// returns exactly one out_ transaction per input, in order.
// out_tuser flags a date that cannot be converted (before 1980-01-06, a year
// above MAX_YEAR, or a month outside 1..12); week and time of week are then 0.
// The cfg_ channel writes the leap-second offset added to the time of week;
// write it only while no transaction is in flight. cfg_ready is always high.
// Throughput is one transaction per cycle while out_tready stays high: the
// five stages are range check and table lookup, day-number sum,
// divide-by-seven multiply, day-of-week scaling, and the week carry.
// Each stage loads whenever it is empty or the stage after it moves, so a
// stalled receiver only holds the output stage while empty stages behind it
// keep filling; in_tready falls only once every stage is full.
// Synchronous reset (rst_n low) empties the pipeline and restores the
// leap-second offset to 17.
module calendar_to_gps_week_time_core
  import c2gw_pkg::*;
#(
  parameter int unsigned MAX_YEAR = 2099
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input transaction.
  input  logic        in_tvalid,
  output logic        in_tready,
  // year[11:0], month[15:12], day[20:16], hour[25:21], minute[31:26],
  // second[37:32], zero pad[39:38].
  input  logic [39:0] in_tdata,
  // Result transaction.
  output logic        out_tvalid,
  input  logic        out_tready,
  // week_number[12:0], time_of_week[32:13], zero pad[39:33].
  output logic [39:0] out_tdata,
  // date_error[0].
  output logic        out_tuser,
  // Leap-second register write.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

`include "assert_macros.svh"

  localparam int unsigned STAGES = 5;

  // The user must let the offset register change only while the pipeline is idle; the block does not enforce this.
  logic [LEAP_W-1:0] leap_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leap_r <= LEAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      leap_r <= cfg_data;
    end
  end

  // Per-stage valid bits and the ready chain that lets bubbles collapse.
  logic [STAGES-1:0] vld_r, vld_nxt, rdy;

  always_comb begin
    rdy[STAGES-1] = !vld_r[STAGES-1] || out_tready;
    for (int i = STAGES-2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
    vld_nxt = vld_r;
    if (rdy[0]) begin
      vld_nxt[0] = in_tvalid;
    end
    for (int i = 1; i < STAGES; i++) begin
      if (rdy[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[STAGES-1];

  day_res_t          day_res;
  logic [WEEK_W-1:0] week_number;
  logic [TOW_W-1:0]  time_of_week;
  logic              date_error;

  c2gw_day_count #(
    .MAX_YEAR(MAX_YEAR)
  ) u_day_count (
    .clk         (clk),
    .en          (rdy[1:0]),
    .year        (in_tdata[11:0]),
    .month       (in_tdata[15:12]),
    .day         (in_tdata[20:16]),
    .hour        (in_tdata[25:21]),
    .minute      (in_tdata[31:26]),
    .second      (in_tdata[37:32]),
    .leap_seconds(leap_r),
    .res         (day_res)
  );

  c2gw_week_split u_week_split (
    .clk         (clk),
    .en          (rdy[4:2]),
    .res         (day_res),
    .week_number (week_number),
    .time_of_week(time_of_week),
    .date_error  (date_error)
  );

  assign out_tdata = {7'b0, time_of_week, week_number};
  assign out_tuser = date_error;

  // An error result carries zero week and time of week.
  `C2GW_ASSERT_IMP(a_err_zero, out_tvalid && out_tuser, out_tdata == 40'd0)
  // A good result always has its week carry applied.
  `C2GW_ASSERT_IMP(a_tow_range, out_tvalid && !out_tuser, time_of_week < TOW_W'(SECS_PER_WEEK))
  // An empty output stage never blocks the input.
  `C2GW_ASSERT_IMP(a_ready_empty, !vld_r[STAGES-1], in_tready)
  // An accepted transaction always lands in the first stage.
  `C2GW_ASSERT_NXT(a_accept_lands, in_tvalid && in_tready, vld_r[0])

endmodule
